[rtl/ffpra_pkg.sv]
// Shared types and constants of the first-fit page run allocator.
package ffpra_pkg;

	localparam int SIZE_W   = 23;
	localparam int PAGE_W   = 10;
	localparam int RUN_W    = 11;
	localparam int STATUS_W = 2;
	localparam int DIVD_W   = SIZE_W + 1;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOSPACE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_MARK,
		ST_FREE_RD,
		ST_FREE_CLR
	} state_t;

endpackage

[rtl/ffpra_ram.sv]
// Simple dual-port synchronous memory with a registered read.
module ffpra_ram #(
	parameter int W = 1,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/ffpra_div.sv]
// Division of a byte count by the page size through a multiply by its reciprocal.
module ffpra_div #(
	parameter int DW = 24,
	parameter int DIVISOR = 4096
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] dividend,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int SHIFT = DW + $clog2(DIVISOR);
	localparam int MW = DW + 2;
	localparam int PW = DW + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((longint'(1) << SHIFT) + longint'(DIVISOR) - longint'(1)) / longint'(DIVISOR));

	logic          done_q;
	logic [DW-1:0] quo_q;
	logic [PW-1:0] prod;

	// The rounded-up reciprocal gives the exact floor quotient for every DW-bit dividend.
	assign prod = PW'(dividend) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= DW'(prod >> SHIFT);
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

[rtl/first_fit_page_run_allocator.sv]
// Top level of the first-fit page run allocator: sequencer around the two page stores.
//
// An item is taken when start is high and busy is low. func selects allocate or free.
// An allocate rounds size_bytes up to whole pages by a multiply with the reciprocal of
// the page size, then reads the occupancy memory one page a cycle from search_start_page
// until it finds a free run long enough, then marks the run one page a cycle. A search
// that reaches the last page without success gives a no-space result, as does a size
// too large for the region. A free reads the run length, then clears the run one page
// a cycle, or gives an invalid result when no run is recorded. An item that is refused
// at once gives its result in the next cycle.
// Each result is shown for one cycle with done high; the receiver cannot stall it, and
// the next item may be started in the cycle in which done is high.
// search_start_page is written through cfg_valid and cfg_data; cfg_ready is always high,
// and writes must be made only while the block is idle; the block does not enforce this.
// After reset both memories are cleared by a pass over every page, during which busy is
// high and no item is taken; configuration writes are still accepted.
module first_fit_page_run_allocator
	import ffpra_pkg::*;
#(
	parameter int HEAP_PAGES = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                func,
	input  logic [SIZE_W-1:0]   size_bytes,
	input  logic [PAGE_W-1:0]   page_index,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [PAGE_W-1:0]   start_page,
	output logic [RUN_W-1:0]    run_pages,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [PAGE_W-1:0]   cfg_data
);

	localparam int AW = $clog2(HEAP_PAGES);
	localparam int CW = $clog2(HEAP_PAGES + 1);
	localparam logic [31:0] HEAP_W = 32'(HEAP_PAGES);

	state_t state_q, state_d;

	logic [PAGE_W-1:0]   search_start_page_q;
	logic [CW-1:0]       clr_q;
	logic [AW-1:0]       idx_q;
	logic [RUN_W-1:0]    len_q;
	logic [CW-1:0]       pages_q;
	logic [AW-1:0]       first_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       addr_q;
	logic [AW-1:0]       addr_s1;
	logic                vld_s1;
	logic [AW-1:0]       mp_q;
	logic [CW-1:0]       rem_q;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [PAGE_W-1:0]   start_page_q;
	logic [RUN_W-1:0]    run_pages_q;

	logic                accept;
	logic [31:0]         idx_w;
	logic [31:0]         start_w;
	logic [31:0]         quo_w;
	logic [31:0]         addr_w;
	logic [31:0]         pages_w;
	logic [31:0]         len_rd_w;
	logic [31:0]         tail_w;
	logic [31:0]         clr_len;
	logic                free_bad;
	logic                nospace;
	logic                found;
	logic                scan_issue;
	logic                scan_fail;
	logic [AW-1:0]       first_new;

	logic                emit;
	logic [STATUS_W-1:0] emit_status;
	logic [31:0]         emit_start;
	logic [31:0]         emit_pages;

	logic                div_go;
	logic                div_done;
	logic [DIVD_W-1:0]   div_q;

	logic                pg_we;
	logic [AW-1:0]       pg_waddr;
	logic                pg_wdata;
	logic                pg_rdata;
	logic                rl_we;
	logic [AW-1:0]       rl_waddr;
	logic [RUN_W-1:0]    rl_wdata;
	logic [RUN_W-1:0]    rl_rdata;

	ffpra_div #(
		.DW(DIVD_W),
		.DIVISOR(PAGE_BYTES)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.go(div_go),
		.dividend(DIVD_W'(size_bytes) + DIVD_W'(PAGE_BYTES - 1)),
		.done(div_done),
		.quotient(div_q)
	);

	ffpra_ram #(
		.W(1),
		.DEPTH(HEAP_PAGES)
	) u_page_taken (
		.clk(clk),
		.we(pg_we),
		.waddr(pg_waddr),
		.wdata(pg_wdata),
		.raddr(addr_q[AW-1:0]),
		.rdata(pg_rdata)
	);

	ffpra_ram #(
		.W(RUN_W),
		.DEPTH(HEAP_PAGES)
	) u_run_length (
		.clk(clk),
		.we(rl_we),
		.waddr(rl_waddr),
		.wdata(rl_wdata),
		.raddr(idx_w[AW-1:0]),
		.rdata(rl_rdata)
	);

	assign accept = start && (state_q == ST_IDLE);
	assign idx_w = 32'(page_index);
	assign start_w = 32'(search_start_page_q);
	assign quo_w = 32'(div_q);
	assign addr_w = 32'(addr_q);
	assign pages_w = 32'(pages_q);
	assign len_rd_w = 32'(rl_rdata);
	assign tail_w = HEAP_W - 32'(idx_q);
	assign clr_len = (len_rd_w < tail_w) ? len_rd_w : tail_w;

	assign free_bad = (idx_w < start_w) || (idx_w >= HEAP_W);
	assign nospace = (start_w >= HEAP_W) || (quo_w > (HEAP_W - start_w));
	assign found = (state_q == ST_SCAN) && vld_s1 && !pg_rdata &&
		((32'(count_q) + 32'd1) == pages_w);
	assign scan_issue = (state_q == ST_SCAN) && !found && (addr_w < HEAP_W);
	assign scan_fail = (state_q == ST_SCAN) && !vld_s1 && (addr_w >= HEAP_W);
	assign first_new = (count_q == '0) ? addr_s1 : first_q;

	always_comb begin
		state_d = state_q;
		emit = 1'b0;
		emit_status = STATUS_OK;
		emit_start = '0;
		emit_pages = '0;
		div_go = 1'b0;
		pg_we = 1'b0;
		pg_waddr = mp_q;
		pg_wdata = 1'b0;
		rl_we = 1'b0;
		rl_waddr = idx_q;
		rl_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				pg_we = 1'b1;
				pg_waddr = clr_q[AW-1:0];
				rl_we = 1'b1;
				rl_waddr = clr_q[AW-1:0];
				if (32'(clr_q) == HEAP_W - 32'd1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_ALLOC) begin
						if (size_bytes == '0) begin
							emit = 1'b1;
							emit_status = STATUS_INVALID;
						end else begin
							div_go = 1'b1;
							state_d = ST_DIV;
						end
					end else if (free_bad) begin
						emit = 1'b1;
						emit_status = STATUS_INVALID;
					end else begin
						state_d = ST_FREE_RD;
					end
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (nospace) begin
						emit = 1'b1;
						emit_status = STATUS_NOSPACE;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (found) begin
					state_d = ST_MARK;
				end else if (scan_fail) begin
					emit = 1'b1;
					emit_status = STATUS_NOSPACE;
					state_d = ST_IDLE;
				end
			end
			ST_MARK: begin
				pg_we = 1'b1;
				pg_waddr = mp_q;
				pg_wdata = 1'b1;
				rl_we = 1'b1;
				rl_waddr = first_q;
				rl_wdata = pages_w[RUN_W-1:0];
				if (rem_q == CW'(1)) begin
					emit = 1'b1;
					emit_status = STATUS_OK;
					emit_start = 32'(first_q);
					emit_pages = pages_w;
					state_d = ST_IDLE;
				end
			end
			ST_FREE_RD: begin
				if (rl_rdata == '0) begin
					emit = 1'b1;
					emit_status = STATUS_INVALID;
					state_d = ST_IDLE;
				end else begin
					rl_we = 1'b1;
					rl_waddr = idx_q;
					rl_wdata = '0;
					state_d = ST_FREE_CLR;
				end
			end
			ST_FREE_CLR: begin
				pg_we = 1'b1;
				pg_waddr = mp_q;
				pg_wdata = 1'b0;
				if (rem_q == CW'(1)) begin
					emit = 1'b1;
					emit_status = STATUS_OK;
					emit_start = 32'(idx_q);
					emit_pages = 32'(len_q);
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			vld_s1 <= 1'b0;
			done_q <= 1'b0;
			search_start_page_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + CW'(1);
			end
			vld_s1 <= scan_issue;
			done_q <= emit;
			if (cfg_valid) begin
				search_start_page_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status_q <= emit_status;
			start_page_q <= emit_start[PAGE_W-1:0];
			run_pages_q <= emit_pages[RUN_W-1:0];
		end
		if (accept) begin
			idx_q <= idx_w[AW-1:0];
		end
		if ((state_q == ST_DIV) && div_done) begin
			pages_q <= quo_w[CW-1:0];
			addr_q <= start_w[CW-1:0];
			count_q <= '0;
		end
		if (scan_issue) begin
			addr_s1 <= addr_q[AW-1:0];
			addr_q <= addr_q + CW'(1);
		end
		if ((state_q == ST_SCAN) && vld_s1) begin
			count_q <= pg_rdata ? '0 : (count_q + CW'(1));
			first_q <= pg_rdata ? first_q : first_new;
		end
		if (found) begin
			mp_q <= first_new;
			rem_q <= pages_q;
		end
		if ((state_q == ST_FREE_RD) && (rl_rdata != '0)) begin
			len_q <= rl_rdata;
			mp_q <= idx_q;
			rem_q <= clr_len[CW-1:0];
		end
		if ((state_q == ST_MARK) || (state_q == ST_FREE_CLR)) begin
			mp_q <= mp_q + AW'(1);
			rem_q <= rem_q - CW'(1);
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign status = status_q;
	assign start_page = start_page_q;
	assign run_pages = run_pages_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STATUS_OK)) |-> ((start_page == '0) && (run_pages == '0)))
		else $error("failed result carries a nonzero page or length");

	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MARK) || (state_q == ST_FREE_CLR)) |-> (rem_q != '0))
		else $error("run walk entered with no pages left");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result without an item in progress");

	a_scan_read: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> ($past(state_q) == ST_SCAN))
		else $error("occupancy read data valid outside the search");

endmodule

[verif/ffpra_checker.sv]
// Checker for the page run allocator: predicts each result and compares it with the block's.
module ffpra_checker
	import ffpra_pkg::*;
#(
	parameter int HEAP_PAGES = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                func,
	input  logic [SIZE_W-1:0]   size_bytes,
	input  logic [PAGE_W-1:0]   page_index,
	input  logic                done,
	input  logic [STATUS_W-1:0] status,
	input  logic [PAGE_W-1:0]   start_page,
	input  logic [RUN_W-1:0]    run_pages,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [PAGE_W-1:0]   cfg_data,
	output int                  failures,
	output int                  pending
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PAGE_W-1:0]   first;
		logic [RUN_W-1:0]    pages;
	} outcome_t;

	bit               page_taken [HEAP_PAGES];
	logic [RUN_W-1:0] run_len [HEAP_PAGES];
	logic [PAGE_W-1:0] region_base;
	outcome_t         outcome_q [$];
	outcome_t         got, want, pred;

	function automatic outcome_t refused(input logic [STATUS_W-1:0] code);
		return '{code, '0, '0};
	endfunction

	task automatic allocate_run(input logic [SIZE_W-1:0] size, output outcome_t r);
		int need, p, count, first;
		if (size == '0) begin
			r = refused(STATUS_INVALID);
			return;
		end
		need = (int'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
		if (int'(region_base) >= HEAP_PAGES || need > HEAP_PAGES - int'(region_base)) begin
			r = refused(STATUS_NOSPACE);
			return;
		end
		count = 0;
		first = 0;
		for (p = int'(region_base); p < HEAP_PAGES && count < need; p++) begin
			if (page_taken[p]) begin
				count = 0;
			end else begin
				if (count == 0)
					first = p;
				count++;
			end
		end
		if (count < need) begin
			r = refused(STATUS_NOSPACE);
			return;
		end
		for (p = first; p < first + need; p++)
			page_taken[p] = 1'b1;
		run_len[first] = RUN_W'(need);
		r = '{STATUS_OK, PAGE_W'(first), RUN_W'(need)};
	endtask

	task automatic release_run(input logic [PAGE_W-1:0] idx, output outcome_t r);
		int len, p;
		if (idx < region_base || int'(idx) >= HEAP_PAGES) begin
			r = refused(STATUS_INVALID);
			return;
		end
		len = int'(run_len[idx]);
		if (len == 0) begin
			r = refused(STATUS_INVALID);
			return;
		end
		for (p = int'(idx); p < HEAP_PAGES && p - int'(idx) < len; p++)
			page_taken[p] = 1'b0;
		run_len[idx] = '0;
		r = '{STATUS_OK, idx, RUN_W'(len)};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HEAP_PAGES; i++) begin
				page_taken[i] = 1'b0;
				run_len[i] = '0;
			end
			region_base = '0;
			outcome_q.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (done) begin
				got = '{status, start_page, run_pages};
				if (outcome_q.size() == 0) begin
					$display("%0t: result with no item outstanding: status %0d start_page %0d run_pages %0d",
						$time, got.status, got.first, got.pages);
					failures++;
				end else begin
					want = outcome_q.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
						failures++;
					end
					if (got.first !== want.first) begin
						$display("%0t: start_page expected %0d actual %0d", $time, want.first, got.first);
						failures++;
					end
					if (got.pages !== want.pages) begin
						$display("%0t: run_pages expected %0d actual %0d", $time, want.pages, got.pages);
						failures++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				region_base = cfg_data;
			if (start && !busy) begin
				if (func == FUNC_ALLOC)
					allocate_run(size_bytes, pred);
				else
					release_run(page_index, pred);
				outcome_q.push_back(pred);
			end
			pending = outcome_q.size();
		end
	end

endmodule

[verif/first_fit_page_run_allocator_tb.sv]
// Testbench top for the page run allocator: clock, reset, stimulus and final verdict.
module first_fit_page_run_allocator_tb;
	import ffpra_pkg::*;

	localparam int HEAP_PAGES   = 1024;
	localparam int PAGE_BYTES   = 4096;
	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 64;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                func;
	logic [SIZE_W-1:0]   size_bytes;
	logic [PAGE_W-1:0]   page_index;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [PAGE_W-1:0]   start_page;
	logic [RUN_W-1:0]    run_pages;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [PAGE_W-1:0]   cfg_data;

	int   failures;
	int   pending;
	int   quiet;
	int   idle_pct;
	logic op_q [$];
	logic done_func;
	int   live_first [$];
	int   live_len [$];
	int   live_pages;

	first_fit_page_run_allocator #(
		.HEAP_PAGES(HEAP_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.size_bytes(size_bytes),
		.page_index(page_index),
		.done(done),
		.status(status),
		.start_page(start_page),
		.run_pages(run_pages),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	ffpra_checker #(
		.HEAP_PAGES(HEAP_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) page_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.size_bytes(size_bytes),
		.page_index(page_index),
		.done(done),
		.status(status),
		.start_page(start_page),
		.run_pages(run_pages),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.failures(failures),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Runs known to be live, so that most frees name a real run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done && op_q.size() > 0) begin
				done_func = op_q.pop_front();
				if (status == STATUS_OK) begin
					if (done_func == FUNC_ALLOC) begin
						live_first.push_back(int'(start_page));
						live_len.push_back(int'(run_pages));
						live_pages += int'(run_pages);
					end else begin
						for (int k = 0; k < live_first.size(); k++) begin
							if (live_first[k] == int'(start_page)) begin
								live_pages -= live_len[k];
								live_first.delete(k);
								live_len.delete(k);
								break;
							end
						end
					end
				end
			end
			if (start && !busy)
				op_q.push_back(func);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet <= 0;
		end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic issue(input logic f, input logic [SIZE_W-1:0] sz, input logic [PAGE_W-1:0] idx);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		if (idle_pct > 0 && $urandom_range(99) < 3) begin
			repeat ($urandom_range(60, 1)) begin
				@(negedge clk);
				start = 1'b0;
			end
		end
		@(negedge clk);
		func = f;
		size_bytes = sz;
		page_index = idx;
		start = 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0 || busy)
			@(negedge clk);
	endtask

	task automatic write_base(input logic [PAGE_W-1:0] base);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = base;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic issue_random();
		int pick, sel, pages, k;
		logic f;
		logic [SIZE_W-1:0] sz;
		logic [PAGE_W-1:0] idx;
		pick = $urandom_range(99);
		sz = SIZE_W'($urandom);
		idx = PAGE_W'($urandom);
		f = FUNC_ALLOC;
		if (pick < 10) begin
			f = FUNC_FREE;
			if (pick >= 5 && live_first.size() > 0) begin
				k = $urandom_range(live_first.size() - 1);
				idx = PAGE_W'(live_first[k] + 1);
			end
		end else if (live_first.size() > 0 && (pick < 45 || (live_pages > 640 && pick < 80))) begin
			f = FUNC_FREE;
			k = $urandom_range(live_first.size() - 1);
			idx = PAGE_W'(live_first[k]);
		end else begin
			sel = $urandom_range(99);
			if (sel < 4) begin
				sz = '0;
			end else if (sel >= 9) begin
				if (sel < 13)
					pages = $urandom_range(HEAP_PAGES, 65);
				else if (sel < 30)
					pages = $urandom_range(64, 9);
				else
					pages = $urandom_range(8, 1);
				sz = SIZE_W'(pages * PAGE_BYTES - int'($urandom_range(PAGE_BYTES - 1)));
			end
		end
		issue(f, sz, idx);
	endtask

	task automatic run_phase(input logic [PAGE_W-1:0] base, input int pct, input int count);
		settle();
		write_base(base);
		idle_pct = pct;
		repeat (count)
			issue_random();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_ALLOC;
		size_bytes = '0;
		page_index = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_pct = 0;
		live_pages = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		write_base('0);
		issue(FUNC_ALLOC, '0, 10'h3FF);
		issue(FUNC_ALLOC, 23'd1, '0);
		issue(FUNC_ALLOC, 23'd4096, '0);
		issue(FUNC_ALLOC, 23'd4097, '0);
		issue(FUNC_ALLOC, 23'd4194304, '0);
		issue(FUNC_ALLOC, 23'h7FFFFF, '0);
		issue(FUNC_FREE, 23'h7FFFFF, 10'd0);
		issue(FUNC_FREE, '0, 10'd0);
		issue(FUNC_FREE, '0, 10'd3);
		issue(FUNC_FREE, '0, 10'h3FF);
		issue(FUNC_FREE, '0, 10'd2);
		issue(FUNC_FREE, '0, 10'd1);
		issue(FUNC_ALLOC, 23'd4194304, '0);
		issue(FUNC_FREE, '0, 10'd0);
		issue(FUNC_ALLOC, 23'd4095, '0);
		settle();
		write_base(10'h3FF);
		issue(FUNC_ALLOC, 23'd8192, '0);
		issue(FUNC_ALLOC, 23'd4096, '0);
		issue(FUNC_ALLOC, 23'd1, '0);
		issue(FUNC_FREE, '0, 10'd0);
		issue(FUNC_FREE, '0, 10'h3FF);
		settle();
		write_base('0);
		issue(FUNC_FREE, '0, 10'd0);

		run_phase('0, 0, 110);
		run_phase(PAGE_W'($urandom_range(1022, 1)), 71, 110);
		run_phase('0, 22, 110);
		run_phase(10'h3FF, 0, 30);
		run_phase(PAGE_W'($urandom_range(1000, 512)), 22, 110);
		run_phase('0, 71, 110);

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
